@@ hdl/md5bh_pkg.sv @@
// ----------------------------------------------------------------------------
// md5bh_pkg
// Shared types, constants and functions for the MD5 block hash.
// ----------------------------------------------------------------------------
package md5bh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned WIDX_W  = $clog2(BLK_WORDS);
    localparam int unsigned RND_W   = 6;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    typedef struct packed {
        logic [WORD_W-1:0] message_word;
        logic              last_word;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] digest_a;
        logic [WORD_W-1:0] digest_b;
        logic [WORD_W-1:0] digest_c;
        logic [WORD_W-1:0] digest_d;
    } t_out;

    typedef struct packed {
        logic              wr_en;
        logic [WIDX_W-1:0] wr_addr;
        logic [WIDX_W-1:0] rd_addr;
        logic              rd_zero;
        logic              load_work;
        logic              pre_sum;
        logic              round_en;
        logic [RND_W-1:0]  rnd;
        logic [RND_W-1:0]  k_idx;
        logic              finish;
        logic              emit;
    } t_cmd;

    function automatic logic [WIDX_W-1:0] md5_idx(input logic [RND_W-1:0] rnd);
        logic [WIDX_W-1:0] m;
        logic [WIDX_W-1:0] res;
        m = rnd[WIDX_W-1:0];
        case (rnd[RND_W-1:RND_W-2])
            2'd0:    res = m;
            2'd1:    res = WIDX_W'(m * 4'd5 + 4'd1);
            2'd2:    res = WIDX_W'(m * 4'd3 + 4'd5);
            default: res = WIDX_W'(m * 4'd7);
        endcase
        return res;
    endfunction

    function automatic logic [4:0] md5_s(input logic [RND_W-1:0] rnd);
        logic [4:0] res;
        case ({rnd[RND_W-1:RND_W-2], rnd[1:0]})
            4'd0:    res = 5'd7;
            4'd1:    res = 5'd12;
            4'd2:    res = 5'd17;
            4'd3:    res = 5'd22;
            4'd4:    res = 5'd5;
            4'd5:    res = 5'd9;
            4'd6:    res = 5'd14;
            4'd7:    res = 5'd20;
            4'd8:    res = 5'd4;
            4'd9:    res = 5'd11;
            4'd10:   res = 5'd16;
            4'd11:   res = 5'd23;
            4'd12:   res = 5'd6;
            4'd13:   res = 5'd10;
            4'd14:   res = 5'd15;
            default: res = 5'd21;
        endcase
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] md5_rotl(input logic [WORD_W-1:0] x,
                                                   input logic [4:0] s);
        logic [2*WORD_W-1:0] w;
        w = {x, x} << s;
        return w[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] md5_k(input logic [RND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

@@ hdl/md5bh_ram.sv @@
// ----------------------------------------------------------------------------
// md5bh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module md5bh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/md5bh_ctrl.sv @@
// ----------------------------------------------------------------------------
// md5bh_ctrl
// Sequencer: collects words, steps the 64 rounds and hands off the digest.
// ----------------------------------------------------------------------------
module md5bh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_word,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output md5bh_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD0   = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0]                     r_state, n_state;
    logic [md5bh_pkg::WIDX_W-1:0]   r_count, n_count;
    logic [md5bh_pkg::RND_W-1:0]    r_rnd, n_rnd;
    logic                           r_last, n_last;
    logic [md5bh_pkg::WIDX_W:0]     r_fill, n_fill;
    logic                           r_out_valid, n_out_valid;
    logic                           accept;
    logic                           blk_done;
    logic [md5bh_pkg::RND_W-1:0]    rd_rnd;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign blk_done    = (r_count == md5bh_pkg::WIDX_W'(md5bh_pkg::BLK_WORDS - 1))
                         || i_last_word;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rnd       = r_rnd;
        n_last      = r_last;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        rd_rnd      = '0;

        o_cmd          = '0;
        o_cmd.wr_addr  = r_count;
        o_cmd.rnd      = r_rnd;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.wr_en = 1'b1;
                    if (blk_done) begin
                        n_count = '0;
                        n_last  = i_last_word;
                        n_fill  = {1'b0, r_count} + 1'b1;
                        n_state = S_RD0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_RD0: begin
                rd_rnd          = '0;
                o_cmd.load_work = 1'b1;
                n_rnd           = '0;
                n_state         = S_RD1;
            end
            S_RD1: begin
                rd_rnd        = md5bh_pkg::RND_W'(1);
                o_cmd.pre_sum = 1'b1;
                o_cmd.k_idx   = '0;
                n_state       = S_ROUND;
            end
            S_ROUND: begin
                rd_rnd         = r_rnd + md5bh_pkg::RND_W'(2);
                o_cmd.round_en = 1'b1;
                o_cmd.k_idx    = r_rnd + 1'b1;
                n_rnd          = r_rnd + 1'b1;
                if (r_rnd == '1) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (!r_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_cmd.rd_addr = md5bh_pkg::md5_idx(rd_rnd);
        o_cmd.rd_zero = ({1'b0, o_cmd.rd_addr} >= r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rnd       <= '0;
            r_last      <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rnd       <= n_rnd;
            r_last      <= n_last;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hdl/md5bh_dp.sv @@
// ----------------------------------------------------------------------------
// md5bh_dp
// Datapath: block word RAM, one MD5 round unit and the chaining words.
// ----------------------------------------------------------------------------
module md5bh_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  md5bh_pkg::t_cmd                i_cmd,
    input  logic [md5bh_pkg::WORD_W-1:0]   i_message_word,
    output md5bh_pkg::t_out                o_out_data
);

    logic [md5bh_pkg::WORD_W-1:0] r_chain_a, r_chain_b, r_chain_c, r_chain_d;
    logic [md5bh_pkg::WORD_W-1:0] r_a, r_b, r_c, r_d;
    logic [md5bh_pkg::WORD_W-1:0] r_sum;
    logic                         r_zero;
    md5bh_pkg::t_out              r_out;
    logic [md5bh_pkg::WORD_W-1:0] ram_q;
    logic [md5bh_pkg::WORD_W-1:0] m_word;
    logic [md5bh_pkg::WORD_W-1:0] f_val;
    logic [md5bh_pkg::WORD_W-1:0] n_b;
    logic [md5bh_pkg::WORD_W-1:0] n_sum;
    logic [md5bh_pkg::WORD_W-1:0] sum_base;
    logic [md5bh_pkg::WORD_W-1:0] new_a, new_b, new_c, new_d;

    md5bh_ram #(
        .WIDTH (md5bh_pkg::WORD_W),
        .DEPTH (md5bh_pkg::BLK_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr),
        .i_wr_data (i_message_word),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (ram_q)
    );

    assign m_word = r_zero ? '0 : ram_q;

    always_comb begin
        case (i_cmd.rnd[md5bh_pkg::RND_W-1:md5bh_pkg::RND_W-2])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
    end

    assign n_b      = r_b + md5bh_pkg::md5_rotl(r_sum + f_val,
                                                md5bh_pkg::md5_s(i_cmd.rnd));
    assign sum_base = i_cmd.pre_sum ? r_a : r_d;
    assign n_sum    = sum_base + md5bh_pkg::md5_k(i_cmd.k_idx) + m_word;

    assign new_a = r_chain_a + r_a;
    assign new_b = r_chain_b + r_b;
    assign new_c = r_chain_c + r_c;
    assign new_d = r_chain_d + r_d;

    always_ff @(posedge i_clk) begin
        r_zero <= i_cmd.rd_zero;
        if (i_cmd.load_work) begin
            r_a <= r_chain_a;
            r_b <= r_chain_b;
            r_c <= r_chain_c;
            r_d <= r_chain_d;
        end else if (i_cmd.round_en) begin
            r_a <= r_d;
            r_b <= n_b;
            r_c <= r_b;
            r_d <= r_c;
        end
        if (i_cmd.pre_sum || i_cmd.round_en) begin
            r_sum <= n_sum;
        end
        if (i_cmd.emit) begin
            r_out.digest_a <= new_a;
            r_out.digest_b <= new_b;
            r_out.digest_c <= new_c;
            r_out.digest_d <= new_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_chain_a <= md5bh_pkg::IV_A;
            r_chain_b <= md5bh_pkg::IV_B;
            r_chain_c <= md5bh_pkg::IV_C;
            r_chain_d <= md5bh_pkg::IV_D;
        end else if (i_cmd.finish) begin
            r_chain_a <= new_a;
            r_chain_b <= new_b;
            r_chain_c <= new_c;
            r_chain_d <= new_d;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ hdl/md5_block_hash.sv @@
// ----------------------------------------------------------------------------
// md5_block_hash
// MD5 compression over an already padded stream of little-endian words.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while the block collects a 16-word block.
// The transfer that completes a block, or that carries last_word, starts a
// compression that holds the input stalled: S_RD0 and S_RD1 prefetch message
// words from the block RAM, S_ROUND runs the single round unit at one round
// per cycle, and S_FINAL folds the result into the chaining words or, for the
// last block, into the output register. Words after an early last_word in a
// block are treated as zero. After a message ends, the digest waits in an
// output register while new words are already accepted; a further digest is
// held back until that one is taken.
module md5_block_hash (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  md5bh_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output md5bh_pkg::t_out o_out_data
);

    md5bh_pkg::t_cmd cmd;

    md5bh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_word (i_in_data.last_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    md5bh_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_word (i_in_data.message_word),
        .o_out_data     (o_out_data)
    );

endmodule

@@ hdl/md5bh_checker.sv @@
// ----------------------------------------------------------------------------
// md5bh_checker
// Port-level checks of the MD5 block hash, bound to the top level.
// ----------------------------------------------------------------------------
module md5bh_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_stall,
    input  md5bh_pkg::t_in  i_in_data,
    input  logic            o_out_valid,
    input  logic            i_out_stall,
    input  md5bh_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Output valid dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("Output payload changed while stalled.");

    a_last_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last_word |=> o_in_stall)
        else $error("Final word transfer did not start a compression.");

    a_digest_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Digest appeared without a preceding compression.");

endmodule

bind md5_block_hash md5bh_checker u_md5bh_checker (.*);
